/* sv/rms_pkg.sv */
// Package for the residue mask sieve: widths, function codes and command/status types.
// No dependencies; imported by every module in sv/.
package rms_pkg;
  localparam int MAX_TABLES = 16;
  localparam int MAX_PRIME  = 32;
  localparam int CURVES     = 16;
  localparam int VALUE_BITS = 32;
  localparam int SLOT_W     = 4;
  localparam int RES_W      = 5;
  localparam int PRIME_W    = 6;
  localparam int ADDR_W     = SLOT_W + 2 * RES_W;
  localparam int MAG_W      = 32;
  localparam int CNT_W      = 48;

  localparam logic [1:0] FUNC_PRIME = 2'd0;
  localparam logic [1:0] FUNC_MASK  = 2'd1;
  localparam logic [1:0] FUNC_TEST  = 2'd2;

  localparam logic [0:0] REG_CURVES = 1'b0;
  localparam logic [0:0] REG_TABLES = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic load_item;   // capture test pair, start gcd
    logic gcd_step;    // one subtract/shift step of binary gcd
    logic mod_start;   // start residues for table in tbl_idx
    logic mod_step;    // one restoring-division bit step
    logic mask_rd;     // issue mask read
    logic mask_and;    // fold read data into running mask
    logic finish;      // form result and bump counters
  } rms_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic gcd_done;
    logic prim;
    logic mod_last;
  } rms_sts_t;
endpackage

/* sv/rms_ctrl.sv */
// Controller FSM for the residue mask sieve.
// Depends on rms_pkg; drives commands into rms_datapath.
module rms_ctrl
  import rms_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [4:0]       n_tables,
  input  rms_sts_t         sts,
  output rms_cmd_t         cmd,
  output logic [SLOT_W-1:0] tbl_idx,
  output logic             busy
);
  typedef enum logic [2:0] {S_IDLE, S_GCD, S_MSTART, S_MOD, S_RD, S_AND, S_FIN} state_t;
  state_t state;
  logic [4:0] left;

  always_comb begin
    cmd = '0;
    cmd.load_item = go;
    unique case (state)
      S_IDLE:   ;
      S_GCD:    cmd.gcd_step = 1'b1;
      S_MSTART: cmd.mod_start = 1'b1;
      S_MOD:    cmd.mod_step = 1'b1;
      S_RD:     cmd.mask_rd = 1'b1;
      S_AND:    cmd.mask_and = 1'b1;
      S_FIN:    cmd.finish = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
      left <= '0;
      tbl_idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (go) begin
          state <= S_GCD;
          busy <= 1'b1;
          tbl_idx <= '0;
          left <= (n_tables > 5'(MAX_TABLES)) ? 5'(MAX_TABLES) : n_tables;
        end
        S_GCD: if (sts.gcd_done) begin
          if (!sts.prim || left == '0) state <= S_FIN;
          else state <= S_MSTART;
        end
        S_MSTART: state <= S_MOD;
        S_MOD: if (sts.mod_last) state <= S_RD;
        S_RD: state <= S_AND;
        S_AND: begin
          left <= left - 5'd1;
          tbl_idx <= tbl_idx + 1'b1;
          state <= (left == 5'd1) ? S_FIN : S_MSTART;
        end
        S_FIN: begin
          state <= S_IDLE;
          busy <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (state == S_FIN) |=> !busy)
    else $error("busy not released after finish");
  assert property (@(posedge clk) disable iff (rst) (state == S_IDLE) |-> !busy)
    else $error("busy high while idle");
  assert property (@(posedge clk) disable iff (rst) (state == S_RD) |=> (state == S_AND))
    else $error("mask read not followed by fold");
endmodule

/* sv/rms_datapath.sv */
// Datapath: table and mask stores, binary gcd, bit-serial residues, counters.
// Depends on rms_pkg; steered by rms_ctrl.
module rms_datapath
  import rms_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               load_ok,
  input  logic [1:0]         func,
  input  logic [SLOT_W-1:0]  table_slot,
  input  logic [PRIME_W-1:0] prime_value,
  input  logic [RES_W-1:0]   residue_num,
  input  logic [RES_W-1:0]   residue_den,
  input  logic [15:0]        mask_word,
  input  logic signed [31:0] numerator,
  input  logic [30:0]        denominator,
  input  logic [4:0]         curve_num,
  input  rms_cmd_t           cmd,
  input  logic [SLOT_W-1:0]  tbl_idx,
  output rms_sts_t           sts,
  output logic               done,
  output logic               is_primitive,
  output logic               is_candidate,
  output logic [15:0]        surviving_mask,
  output logic signed [31:0] echo_numerator,
  output logic [30:0]        echo_denominator,
  output logic [CNT_W-1:0]   primitive_total,
  output logic [CNT_W-1:0]   candidate_total
);
  logic [PRIME_W-1:0] primes [MAX_TABLES];
  logic [15:0] mstore [2**ADDR_W];
  logic [15:0] rd_data, mask;
  logic signed [31:0] num_q;
  logic [30:0] den_q;
  logic neg;
  logic [MAG_W-1:0] mag;
  // binary gcd: gx, gy, common shift flag
  logic [MAG_W-1:0] gx, gy;
  logic gtwo, prim;
  // residues: shift magnitudes MSB-first through remainders
  logic [MAG_W-1:0] sa, sb;
  logic [PRIME_W:0] ra, rb;
  logic [PRIME_W-1:0] p;
  logic [5:0] bit_cnt;
  logic [PRIME_W:0] ra_sh, rb_sh, ra_n, rb_n;
  logic [PRIME_W-1:0] a_res, b_res;
  logic [4:0] cc;
  logic [CNT_W-1:0] pc_next;

  always_ff @(posedge clk) begin
    if (load_ok && func == FUNC_PRIME && prime_value >= 6'd2
        && prime_value <= 6'(MAX_PRIME))
      primes[table_slot] <= prime_value;
    if (load_ok && func == FUNC_MASK)
      mstore[{table_slot, residue_num, residue_den}] <= mask_word;
    // residues are below the prime, so the low RES_W bits carry them
    if (cmd.mask_rd)
      rd_data <= mstore[{tbl_idx, a_res[RES_W-1:0], b_res[RES_W-1:0]}];
  end

  assign ra_sh = {ra[PRIME_W-1:0], sa[MAG_W-1]};
  assign rb_sh = {rb[PRIME_W-1:0], sb[MAG_W-1]};
  assign ra_n = (ra_sh >= {1'b0, p}) ? ra_sh - {1'b0, p} : ra_sh;
  assign rb_n = (rb_sh >= {1'b0, p}) ? rb_sh - {1'b0, p} : rb_sh;
  always_comb begin
    a_res = ra[PRIME_W-1:0];
    if (neg && ra != '0) a_res = p - ra[PRIME_W-1:0];
  end
  assign b_res = rb[PRIME_W-1:0];
  assign cc = (curve_num > 5'(CURVES)) ? 5'(CURVES) : curve_num;
  assign sts.mod_last = (bit_cnt == 6'd31);
  // verdict is valid in the cycle gcd_done is high
  assign sts.prim = !gtwo && ((gx | gy) == 32'd1);
  // gcd done when one operand is zero; gcd==1 iff other is 1 and no common shift
  assign sts.gcd_done = (gx == '0) || (gy == '0);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      num_q <= numerator;
      den_q <= denominator;
      neg <= numerator[31];
      mag <= numerator[31] ? 32'(-numerator) : numerator;
      gx <= numerator[31] ? 32'(-numerator) : numerator;
      gy <= {1'b0, denominator};
      gtwo <= 1'b0;
    end else if (cmd.gcd_step) begin
      if (gx == '0 || gy == '0) begin
        prim <= !gtwo && ((gx | gy) == 32'd1);
      end else if (!gx[0] && !gy[0]) begin
        gtwo <= 1'b1;
        gx <= gx >> 1;
        gy <= gy >> 1;
      end else if (!gx[0]) gx <= gx >> 1;
      else if (!gy[0]) gy <= gy >> 1;
      else if (gx >= gy) gx <= (gx - gy) >> 1;
      else gy <= (gy - gx) >> 1;
    end
    if (cmd.mod_start) begin
      p <= primes[tbl_idx];
      sa <= mag;
      sb <= {1'b0, den_q};
      ra <= '0;
      rb <= '0;
      bit_cnt <= '0;
    end else if (cmd.mod_step) begin
      sa <= sa << 1;
      sb <= sb << 1;
      ra <= ra_n;
      rb <= rb_n;
      bit_cnt <= bit_cnt + 6'd1;
    end
    if (cmd.load_item) mask <= 16'((17'd1 << cc) - 17'd1);
    else if (cmd.mask_and) mask <= mask & rd_data;
  end

  assign pc_next = (primitive_total != '1) ? primitive_total + 1'b1 : primitive_total;
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      primitive_total <= '0;
      candidate_total <= '0;
    end else begin
      done <= cmd.finish;
      if (cmd.finish) begin
        is_primitive <= prim;
        is_candidate <= prim && ($countones(mask) >= 2);
        surviving_mask <= (prim && ($countones(mask) >= 2)) ? mask : '0;
        echo_numerator <= num_q;
        echo_denominator <= den_q;
        if (prim) primitive_total <= pc_next;
        if (prim && $countones(mask) >= 2 && candidate_total != '1)
          candidate_total <= candidate_total + 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> (is_candidate -> is_primitive))
    else $error("candidate without primitive");
  assert property (@(posedge clk) disable iff (rst) done |-> ($countones(surviving_mask) != 1))
    else $error("single-bit surviving mask");
  assert property (@(posedge clk) disable iff (rst) candidate_total <= primitive_total)
    else $error("candidate count exceeds primitive count");
endmodule

/* sv/residue_mask_sieve.sv */
// Top level of the residue mask sieve: port wrapper, config registers,
// controller (rms_ctrl) and datapath (rms_datapath). Uses rms_pkg.
//
// Usage: pulse start with func and the fields; a request is taken when start
// is high and busy is low. Load requests (set prime, write mask) finish in the
// cycle they are taken and never raise busy. A test request raises busy and
// runs: binary gcd (one subtract/shift per cycle), then for each active table
// a setup step, 32 bit-serial residue steps for both operands, a mask read
// and a fold. Non-primitive pairs skip the tables. After the last fold (or
// the gcd, if no table runs) the finish state registers the result and
// valid. A new request can be taken in the valid cycle. The result appears
// for one cycle with valid high; the receiver cannot stall and must take it.
// cfg_we/cfg_index/cfg_data write the curve count (index 0) and active_tables
// (index 1); the user must write them only while idle, and the block itself
// does not enforce it. Reset sets the curve count 16, active_tables 1, clears
// the counters; the prime and mask stores hold nothing until written.
module residue_mask_sieve
  import rms_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_data,
  input  logic [1:0]         func,
  input  logic [3:0]         table_slot,
  input  logic [5:0]         prime_value,
  input  logic [4:0]         residue_num,
  input  logic [4:0]         residue_den,
  input  logic [15:0]        mask_word,
  input  logic signed [31:0] numerator,
  input  logic [30:0]        denominator,
  output logic               valid,
  output logic               is_primitive,
  output logic               is_candidate,
  output logic [15:0]        surviving_mask,
  output logic signed [31:0] echo_numerator,
  output logic [30:0]        echo_denominator,
  output logic [47:0]        primitive_total,
  output logic [47:0]        candidate_total
);
  logic [4:0] curve_num, active_tables;
  logic take;
  rms_cmd_t cmd;
  rms_sts_t sts;
  logic [SLOT_W-1:0] tbl_idx;

  assign take = start && !busy;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_num <= 5'd16;
      active_tables <= 5'd1;
    end else if (cfg_we) begin
      if (cfg_index == REG_CURVES) curve_num <= cfg_data;
      else active_tables <= cfg_data;
    end
  end

  rms_ctrl u_ctrl (
    .clk, .rst,
    .go(take && func == FUNC_TEST),
    .n_tables(active_tables),
    .sts, .cmd, .tbl_idx, .busy
  );

  rms_datapath u_dp (
    .clk, .rst,
    .load_ok(take),
    .func, .table_slot, .prime_value, .residue_num, .residue_den, .mask_word,
    .numerator, .denominator, .curve_num,
    .cmd, .tbl_idx, .sts,
    .done(valid),
    .is_primitive, .is_candidate, .surviving_mask,
    .echo_numerator, .echo_denominator, .primitive_total, .candidate_total
  );

  assert property (@(posedge clk) disable iff (rst) valid |-> !busy)
    else $error("result while busy");
  assert property (@(posedge clk) disable iff (rst) (take && func == FUNC_TEST) |=> busy)
    else $error("test request did not raise busy");
  assert property (@(posedge clk) disable iff (rst) valid |=> !valid)
    else $error("result held more than one cycle");
endmodule
